[rtl/tked_pkg.sv]
// shared types and constants of the terminal key escape decoder
`default_nettype none

package tked_pkg;

  // decoder phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ESC  = 4'b0010,
    PH_CSI  = 4'b0100,
    PH_SS3  = 4'b1000
  } phase_t;

  // key codes
  typedef enum logic [3:0] {
    K_CHAR  = 4'd0,
    K_ENTER = 4'd1,
    K_TAB   = 4'd2,
    K_BACK  = 4'd3,
    K_ESC   = 4'd4,
    K_UP    = 4'd5,
    K_DOWN  = 4'd6,
    K_RIGHT = 4'd7,
    K_LEFT  = 4'd8,
    K_HOME  = 4'd9,
    K_END   = 4'd10,
    K_DEL   = 4'd11,
    K_PGUP  = 4'd12,
    K_PGDN  = 4'd13
  } key_type_t;

  // item kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam logic REG_ESC_WAIT = 1'b0;
  localparam logic REG_SEQ_WAIT = 1'b1;

  // byte codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_CTRLZ = 8'h1A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_US    = 8'h1F;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SS3   = 8'h4F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_SIX   = 8'h36;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_LOWA  = 8'h60;

  localparam logic [15:0] WAIT_MAX = 16'hFFFF;
  localparam logic [15:0] ESC_WAIT_RST = 16'd25;
  localparam logic [15:0] SEQ_WAIT_RST = 16'd50;

  // one input item
  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  // one decoded key event
  typedef struct packed {
    key_type_t  key_type;
    logic [7:0] key_char;
    logic       alt_flag;
    logic       ctrl_flag;
    logic       shift_flag;
  } key_t;

  // arrow and home/end final bytes, K_CHAR when none
  function automatic key_type_t nav_key(input logic [7:0] fb);
    key_type_t k;
    unique case (fb)
      8'h41:   k = K_UP;
      8'h42:   k = K_DOWN;
      8'h43:   k = K_RIGHT;
      8'h44:   k = K_LEFT;
      8'h48:   k = K_HOME;
      8'h46:   k = K_END;
      default: k = K_CHAR;
    endcase
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

[rtl/tked_decode.sv]
// decoder state and per-item decode logic
`default_nettype none

module tked_decode #(
  parameter int SEQ_MAX = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              fire,
  input  tked_pkg::item_t  item,
  input  wire [15:0]       esc_wait,
  input  wire [15:0]       seq_wait,
  output logic             res_valid,
  output tked_pkg::key_t   res
);
  import tked_pkg::*;

  localparam int CW = (SEQ_MAX > 1) ? $clog2(SEQ_MAX) : 1;

  phase_t      phase, phase_next;
  logic [15:0] wait_count, wait_count_next;
  logic [CW-1:0] seq_count, seq_count_next;
  logic [7:0]  first_byte, first_byte_next;
  // modifier tracking since the last ';' of the held sequence
  logic        semi_seen, semi_seen_next;
  logic        mod_nonempty, mod_nonempty_next;
  logic        mod_digits, mod_digits_next;
  logic        mod_nonzero, mod_nonzero_next;
  logic        mod_even, mod_even_next;

  logic [7:0]  b;
  logic [15:0] wait_inc, limit;
  logic        b_digit, csi_final;
  logic [7:0]  b0;
  key_type_t   k;
  key_t        csi_res;

  assign b = item.data_byte;
  assign b_digit = is_digit(b);
  assign wait_inc = (wait_count != WAIT_MAX) ? wait_count + 16'd1 : wait_count;
  assign limit = (phase == PH_ESC) ? esc_wait : seq_wait;
  assign csi_final = ((b >= CH_UPA) && (b <= CH_UPZ)) || (b == CH_TILDE) ||
                     (seq_count == CW'(SEQ_MAX - 1));
  assign b0 = (seq_count == '0) ? b : first_byte;
  assign k = nav_key(b);

  // csi sequence decode at its final byte
  always_comb begin
    csi_res = '0;
    csi_res.key_type = K_ESC;
    priority if (seq_count == CW'(0) && k != K_CHAR) begin
      csi_res.key_type = k;
    end else if (seq_count == CW'(1) && k != K_CHAR && is_digit(b0) &&
                 b0 != CH_ZERO && !b0[0]) begin
      csi_res.key_type = k;
      csi_res.shift_flag = 1'b1;
    end else if (b == CH_TILDE && (b0 == CH_ONE || b0 == CH_SEVEN)) begin
      csi_res.key_type = K_HOME;
    end else if (b == CH_TILDE && b0 == CH_THREE) begin
      csi_res.key_type = K_DEL;
    end else if (b == CH_TILDE && (b0 == CH_FOUR || b0 == CH_EIGHT)) begin
      csi_res.key_type = K_END;
    end else if (b == CH_TILDE && b0 == CH_FIVE) begin
      csi_res.key_type = K_PGUP;
    end else if (b == CH_TILDE && b0 == CH_SIX) begin
      csi_res.key_type = K_PGDN;
    end else if (b != CH_SEMI && semi_seen && mod_nonempty && k != K_CHAR) begin
      csi_res.key_type = k;
      csi_res.shift_flag = mod_digits && mod_nonzero && mod_even;
    end else begin
      csi_res.key_type = K_ESC;
    end
  end

  // next state and result
  always_comb begin
    phase_next        = phase;
    wait_count_next   = wait_count;
    seq_count_next    = seq_count;
    first_byte_next   = first_byte;
    semi_seen_next    = semi_seen;
    mod_nonempty_next = mod_nonempty;
    mod_digits_next   = mod_digits;
    mod_nonzero_next  = mod_nonzero;
    mod_even_next     = mod_even;
    res_valid         = 1'b0;
    res               = '0;
    if (item.op == OP_TICK) begin
      if (phase != PH_IDLE) begin
        if (wait_inc >= limit) begin
          phase_next      = PH_IDLE;
          wait_count_next = '0;
          res_valid       = 1'b1;
          res.key_type    = K_ESC;
        end else begin
          wait_count_next = wait_inc;
        end
      end
    end else begin
      wait_count_next = '0;
      unique case (phase)
        PH_ESC: begin
          if (b == CH_LBRK) begin
            phase_next        = PH_CSI;
            seq_count_next    = '0;
            semi_seen_next    = 1'b0;
            mod_nonempty_next = 1'b0;
            mod_digits_next   = 1'b1;
            mod_nonzero_next  = 1'b0;
            mod_even_next     = 1'b0;
          end else if (b == CH_SS3) begin
            phase_next = PH_SS3;
          end else begin
            phase_next   = PH_IDLE;
            res_valid    = 1'b1;
            res.key_type = K_CHAR;
            res.key_char = b;
            res.alt_flag = 1'b1;
          end
        end
        PH_CSI: begin
          if (seq_count == '0) begin
            first_byte_next = b;
          end
          if (csi_final) begin
            phase_next     = PH_IDLE;
            seq_count_next = '0;
            res_valid      = 1'b1;
            res            = csi_res;
          end else begin
            seq_count_next = seq_count + CW'(1);
            if (b == CH_SEMI) begin
              semi_seen_next    = 1'b1;
              mod_nonempty_next = 1'b0;
              mod_digits_next   = 1'b1;
              mod_nonzero_next  = 1'b0;
              mod_even_next     = 1'b0;
            end else begin
              mod_nonempty_next = 1'b1;
              mod_digits_next   = mod_digits && b_digit;
              mod_nonzero_next  = mod_nonzero || (b_digit && b != CH_ZERO);
              mod_even_next     = b_digit && !b[0];
            end
          end
        end
        PH_SS3: begin
          phase_next = PH_IDLE;
          res_valid  = 1'b1;
          if (b == 8'h48) begin
            res.key_type = K_HOME;
          end else if (b == 8'h46) begin
            res.key_type = K_END;
          end else begin
            res.key_type = K_ESC;
          end
        end
        PH_IDLE: begin
          res_valid = 1'b1;
          priority if (b == CH_ESC) begin
            phase_next = PH_ESC;
            res_valid  = 1'b0;
          end else if (b == CH_CR) begin
            res.key_type = K_ENTER;
          end else if (b == CH_TAB) begin
            res.key_type = K_TAB;
          end else if (b == CH_BS || b == CH_DEL) begin
            res.key_type = K_BACK;
          end else if (b != CH_NUL && b <= CH_CTRLZ) begin
            res.key_type  = K_CHAR;
            res.key_char  = b + CH_LOWA;
            res.ctrl_flag = 1'b1;
          end else if (b == CH_US) begin
            res.key_type  = K_CHAR;
            res.key_char  = CH_SLASH;
            res.ctrl_flag = 1'b1;
          end else begin
            res.key_type = K_CHAR;
            res.key_char = b;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      wait_count   <= '0;
      seq_count    <= '0;
      semi_seen    <= 1'b0;
      mod_nonempty <= 1'b0;
      mod_digits   <= 1'b1;
      mod_nonzero  <= 1'b0;
      mod_even     <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      wait_count   <= wait_count_next;
      seq_count    <= seq_count_next;
      semi_seen    <= semi_seen_next;
      mod_nonempty <= mod_nonempty_next;
      mod_digits   <= mod_digits_next;
      mod_nonzero  <= mod_nonzero_next;
      mod_even     <= mod_even_next;
    end
  end

  // first sequence byte, payload only
  always_ff @(posedge clk) begin
    if (fire) begin
      first_byte <= first_byte_next;
    end
  end

endmodule

`default_nettype wire

[rtl/terminal_key_escape_decoder.sv]
// Terminal key escape decoder: keyboard bytes and millisecond ticks in,
// key events out.
// Input stream: s_tdata carries the received byte, s_tuser the item kind
// (0 byte, 1 tick). Output stream: m_tdata carries the character code,
// m_tuser the key type and the alt, ctrl and shift flags.
// An item produces zero or one key event. Plain bytes, ESC sequences
// (CSI and SS3) and the escape timeout are all decoded here.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 escape wait ticks, 1 sequence wait ticks); write only while idle.
// Throughput is one item per cycle while the receiver does not stall: the
// decode is a single pass of logic between the input register and the
// output register, and each beat passes through both registers in turn.
// When the receiver stalls, the output register holds its beat and the
// input register holds one more item; s_tready drops once both are full.
// Synchronous reset returns to the idle phase, clears both stages and
// loads the wait registers with 25 and 50 ticks.
`default_nettype none

module terminal_key_escape_decoder #(
  parameter int SEQ_MAX = 8
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [7:0]  s_tdata,   // [7:0] data_byte
  input  wire        s_tuser,   // [0] op
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // [7:0] key_char
  output logic [6:0] m_tuser,   // [3:0] key_type, [4] alt_flag, [5] ctrl_flag, [6] shift_flag
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [15:0] cfg_wdata
);
  import tked_pkg::*;

  logic        in_valid;
  item_t       in_item;
  logic [15:0] esc_wait;
  logic [15:0] seq_wait;
  logic        advance;
  logic        res_valid;
  key_t        res;
  key_t        out_key;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      esc_wait <= ESC_WAIT_RST;
      seq_wait <= SEQ_WAIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ESC_WAIT: esc_wait <= cfg_wdata;
        REG_SEQ_WAIT: seq_wait <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.op        <= s_tuser;
      in_item.data_byte <= s_tdata;
    end
  end

  tked_decode #(
    .SEQ_MAX(SEQ_MAX)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .fire     (in_valid && advance),
    .item     (in_item),
    .esc_wait (esc_wait),
    .seq_wait (seq_wait),
    .res_valid(res_valid),
    .res      (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && res_valid) begin
      out_key <= res;
    end
  end

  assign m_tdata = out_key.key_char;
  assign m_tuser = {out_key.shift_flag, out_key.ctrl_flag, out_key.alt_flag,
                    out_key.key_type};

endmodule

`default_nettype wire
